>>> hw/rtl/arlt_pkg.sv
// Shared types and constants of the rate and acceleration limited tracker.
`default_nettype none

package arlt_pkg;

    localparam int ARG_W  = 34;
    localparam int GAIN_W = 32;
    localparam int PROD_W = 64;
    localparam int HI_W   = 48;
    localparam int MAG_W  = 50;
    localparam int TERM_W = 52;
    localparam int LIM_W  = 31;
    localparam int OUT_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd4;

    localparam logic [GAIN_W-1:0] RST_POSITION_GAIN = 32'd662319268;
    localparam logic [GAIN_W-1:0] RST_VELOCITY_GAIN = 32'd13176793;
    localparam logic [LIM_W-1:0]  RST_MAX_RATE      = 31'h7FFFFFFF;
    localparam logic [LIM_W-1:0]  RST_MAX_ACCEL     = 31'h7FFFFFFF;
    localparam logic [GAIN_W-1:0] RST_TIME_STEP     = 32'd4294967;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PE,
        ST_MUL_RV,
        ST_RND_RV,
        ST_ACCEL,
        ST_MUL_AD,
        ST_RND_AD,
        ST_RATE,
        ST_MUL_RD,
        ST_RND_RD,
        ST_POS,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MS_ERR_PG,
        MS_RATE_VG,
        MS_ACCEL_DT,
        MS_RATE_DT
    } mul_sel_t;

    typedef enum logic [2:0] {
        AP_NONE,
        AP_HOLD,
        AP_ACCEL,
        AP_RATE,
        AP_POS
    } apply_t;

    typedef struct packed {
        logic     load;
        logic     load_op;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     round_en;
        apply_t   apply;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/arlt_ctrl.sv
// Sequencing state machine of the tracker: accept, four product steps, result.
`default_nettype none

module arlt_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_op,
    output logic                    in_ready,
    input  wire arlt_pkg::dp_status_t status,
    output arlt_pkg::dp_cmd_t       cmd
);
    import arlt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = MS_ERR_PG;
        cmd.apply    = AP_NONE;
        cmd.load_op  = in_op;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_op ? ST_DONE : ST_MUL_PE;
                end
            end
            ST_MUL_PE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ERR_PG;
                state_next  = ST_MUL_RV;
            end
            ST_MUL_RV:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MS_RATE_VG;
                cmd.round_en = 1'b1;
                state_next   = ST_RND_RV;
            end
            ST_RND_RV:
            begin
                cmd.round_en = 1'b1;
                cmd.apply    = AP_HOLD;
                state_next   = ST_ACCEL;
            end
            ST_ACCEL:
            begin
                cmd.apply  = AP_ACCEL;
                state_next = ST_MUL_AD;
            end
            ST_MUL_AD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ACCEL_DT;
                state_next  = ST_RND_AD;
            end
            ST_RND_AD:
            begin
                cmd.round_en = 1'b1;
                state_next   = ST_RATE;
            end
            ST_RATE:
            begin
                cmd.apply  = AP_RATE;
                state_next = ST_MUL_RD;
            end
            ST_MUL_RD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_RATE_DT;
                state_next  = ST_RND_RD;
            end
            ST_RND_RD:
            begin
                cmd.round_en = 1'b1;
                state_next   = ST_POS;
            end
            ST_POS:
            begin
                cmd.apply  = AP_POS;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/arlt_dp.sv
// Datapath of the tracker: settings, filter state, shared multiplier and output word.
`default_nettype none

module arlt_dp #(
    parameter int SIG_W = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire arlt_pkg::dp_cmd_t                 cmd,
    output arlt_pkg::dp_status_t                   status,
    input  wire logic                              cfg_valid,
    input  wire logic [arlt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [arlt_pkg::GAIN_W-1:0]       cfg_data,
    input  wire logic signed [arlt_pkg::OUT_W-1:0] in_sample,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [arlt_pkg::OUT_W-1:0]             out_position,
    output logic [arlt_pkg::OUT_W-1:0]             out_rate,
    output logic [arlt_pkg::OUT_W-1:0]             out_accel,
    output logic                                   out_initialized
);
    import arlt_pkg::*;

    localparam logic signed [TERM_W-1:0] SIG_MAX_T =
        signed'(TERM_W'({(SIG_W-1){1'b1}}));
    localparam logic signed [TERM_W-1:0] SIG_MIN_T = ~SIG_MAX_T;

    logic [GAIN_W-1:0] position_gain_reg;
    logic [GAIN_W-1:0] velocity_gain_reg;
    logic [LIM_W-1:0]  max_rate_reg;
    logic [LIM_W-1:0]  max_accel_reg;
    logic [GAIN_W-1:0] time_step_reg;

    logic signed [SIG_W-1:0] sample_reg;
    logic signed [SIG_W-1:0] position_reg;
    logic signed [SIG_W-1:0] rate_reg;
    logic signed [SIG_W-1:0] accel_reg;
    logic                    seeded_reg;

    logic [PROD_W-1:0]        prod_reg;
    logic [HI_W-1:0]          hiterm_reg;
    logic                     neg_reg;
    logic                     s16_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [TERM_W-1:0] hold_reg;

    logic                     out_valid_reg;
    logic [OUT_W-1:0]         out_position_reg;
    logic [OUT_W-1:0]         out_rate_reg;
    logic [OUT_W-1:0]         out_accel_reg;
    logic                     out_init_reg;

    logic signed [ARG_W-1:0]  arg;
    logic [ARG_W-1:0]         arg_mag;
    logic [GAIN_W-1:0]        gain;
    logic                     s16;
    logic [PROD_W-1:0]        prod_next;
    logic [HI_W-1:0]          hiterm_next;
    logic [HI_W-1:0]          shifted;
    logic                     rbit;
    logic [MAG_W-1:0]         mag;
    logic signed [TERM_W-1:0] term_next;
    logic signed [SIG_W-1:0]  sample_sat;

    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [TERM_W-1:0] v);
        logic signed [TERM_W-1:0] c;
        c = v;
        if (c > SIG_MAX_T)
        begin
            c = SIG_MAX_T;
        end
        if (c < SIG_MIN_T)
        begin
            c = SIG_MIN_T;
        end
        return c[SIG_W-1:0];
    endfunction

    function automatic logic signed [SIG_W-1:0] clamp_sym(input logic signed [TERM_W-1:0] v,
                                                          input logic [LIM_W-1:0] lim);
        logic signed [TERM_W-1:0] l;
        logic signed [TERM_W-1:0] c;
        l = signed'(TERM_W'(lim));
        c = v;
        if (c > l)
        begin
            c = l;
        end
        if (c < -l)
        begin
            c = -l;
        end
        return sat_sig(c);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_gain_reg <= RST_POSITION_GAIN;
            velocity_gain_reg <= RST_VELOCITY_GAIN;
            max_rate_reg      <= RST_MAX_RATE;
            max_accel_reg     <= RST_MAX_ACCEL;
            time_step_reg     <= RST_TIME_STEP;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POSITION_GAIN: position_gain_reg <= cfg_data;
                CFG_VELOCITY_GAIN: velocity_gain_reg <= cfg_data;
                CFG_MAX_RATE:      max_rate_reg      <= cfg_data[LIM_W-1:0];
                CFG_MAX_ACCEL:     max_accel_reg     <= cfg_data[LIM_W-1:0];
                CFG_TIME_STEP:     time_step_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign sample_sat = sat_sig(TERM_W'(in_sample));

    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_ERR_PG:
            begin
                arg  = ARG_W'(sample_reg) - ARG_W'(position_reg);
                gain = position_gain_reg;
                s16  = 1'b1;
            end
            MS_RATE_VG:
            begin
                arg  = ARG_W'(rate_reg);
                gain = velocity_gain_reg;
                s16  = 1'b1;
            end
            MS_ACCEL_DT:
            begin
                arg  = ARG_W'(accel_reg);
                gain = time_step_reg;
                s16  = 1'b0;
            end
            MS_RATE_DT:
            begin
                arg  = ARG_W'(rate_reg);
                gain = time_step_reg;
                s16  = 1'b0;
            end
            default:
            begin
                arg  = '0;
                gain = '0;
                s16  = 1'b0;
            end
        endcase
        arg_mag   = arg[ARG_W-1] ? ARG_W'(-arg) : ARG_W'(arg);
        prod_next = PROD_W'(arg_mag[GAIN_W-1:0]) * PROD_W'(gain);
        if (arg_mag[GAIN_W])
        begin
            hiterm_next = s16 ? {gain, 16'b0} : HI_W'(gain);
        end
        else
        begin
            hiterm_next = '0;
        end
    end

    always_comb
    begin
        shifted   = s16_reg ? prod_reg[PROD_W-1:16] : HI_W'(prod_reg[PROD_W-1:32]);
        rbit      = s16_reg ? prod_reg[15] : prod_reg[31];
        mag       = MAG_W'(hiterm_reg) + MAG_W'(shifted) + MAG_W'(rbit);
        term_next = neg_reg ? -signed'(TERM_W'(mag)) : signed'(TERM_W'(mag));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg   <= prod_next;
            hiterm_reg <= hiterm_next;
            neg_reg    <= arg[ARG_W-1];
            s16_reg    <= s16;
        end
        if (cmd.round_en)
        begin
            term_reg <= term_next;
        end
        if (cmd.apply == AP_HOLD)
        begin
            hold_reg <= term_reg;
        end
        if (cmd.load && !cmd.load_op)
        begin
            sample_reg <= sample_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            rate_reg     <= '0;
            accel_reg    <= '0;
            seeded_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (cmd.load_op)
            begin
                rate_reg   <= '0;
                accel_reg  <= '0;
                seeded_reg <= 1'b0;
            end
            else if (!seeded_reg)
            begin
                position_reg <= sample_sat;
                rate_reg     <= '0;
                accel_reg    <= '0;
                seeded_reg   <= 1'b1;
            end
        end
        else
        begin
            unique case (cmd.apply)
                AP_ACCEL: accel_reg    <= clamp_sym(hold_reg - term_reg, max_accel_reg);
                AP_RATE:  rate_reg     <= clamp_sym(TERM_W'(rate_reg) + term_reg, max_rate_reg);
                AP_POS:   position_reg <= sat_sig(TERM_W'(position_reg) + term_reg);
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_position_reg <= OUT_W'(position_reg);
            out_rate_reg     <= OUT_W'(rate_reg);
            out_accel_reg    <= OUT_W'(accel_reg);
            out_init_reg     <= seeded_reg;
        end
    end

    assign status.out_busy  = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign out_position     = out_position_reg;
    assign out_rate         = out_rate_reg;
    assign out_accel        = out_accel_reg;
    assign out_initialized  = out_init_reg;

endmodule

`default_nettype wire

>>> hw/rtl/accel_rate_limited_tracker.sv
// Top level of the rate and acceleration limited second-order tracker.
//
// For a filter word, the acceleration, rate and position updates need four
// dependent products, and all of them go through one shared 32x32 multiplier
// in multiply, round and apply steps, with the two gain products overlapped.
// A reset word goes straight from acceptance to the result step. The next
// word is accepted once the sequencer is idle again, which can happen while
// the previous result still waits in the output register; no new word is
// taken while the last filter word is still in work. Settings
// should be written only while the block is idle.
`default_nettype none

module accel_rate_limited_tracker #(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] sample
    input  wire logic [0:0]  s_axis_tuser,   // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // [31:0] position, [63:32] rate, [95:64] accel
    output logic [0:0]       m_axis_tuser,   // [0] initialized
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import arlt_pkg::*;

    localparam int SIG_W = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 18) ? 18 : DATA_WIDTH);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [OUT_W-1:0] out_position;
    logic [OUT_W-1:0] out_rate;
    logic [OUT_W-1:0] out_accel;
    logic             out_initialized;

    arlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    arlt_dp #(
        .SIG_W (SIG_W)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_sample       (signed'(s_axis_tdata)),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_position    (out_position),
        .out_rate        (out_rate),
        .out_accel       (out_accel),
        .out_initialized (out_initialized)
    );

    assign cfg_ready       = 1'b1;
    assign m_axis_tdata    = {out_accel, out_rate, out_position};
    assign m_axis_tuser[0] = out_initialized;

endmodule

`default_nettype wire

>>> hw/rtl/arlt_checker.sv
// Port-level checks of the tracker, bound to its top level.
`default_nettype none

module arlt_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // A result word holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Each word is worked on alone, so the input closes right after an acceptance.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted a word while another was in work");

    // An unseeded result only follows a reset word, which clears rate and acceleration.
    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[95:32] == 64'd0)
        else $error("unseeded result carries nonzero rate or acceleration");

endmodule

bind accel_rate_limited_tracker arlt_checker u_arlt_checker (.*);

`default_nettype wire
